>>> rtl/core/wls_pkg.sv
package wls_pkg;

	localparam int MAX_LINES_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int ENERGY_W        = 32;
	localparam int WEIGHT_W        = 16;
	localparam int FRAC_W          = 32;
	localparam int INDEX_W         = 4;
	localparam int KIND_W          = 2;

	typedef enum logic [0:0] {
		CMD_ADD    = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		STAT_SAMPLED = 2'd0,
		STAT_ADDED   = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		OP_ADD    = 2'd0,
		OP_FULL   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_EMPTY  = 2'd3
	} op_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE   = 3'd0,
		BK_MUL_LO = 3'd1,
		BK_MUL_HI = 3'd2,
		BK_THR    = 3'd3,
		BK_READ   = 3'd4,
		BK_CMP    = 3'd5
	} back_state_t;

	typedef struct packed {
		command_t             command;
		logic [ENERGY_W-1:0]  line_energy;
		logic [WEIGHT_W-1:0]  line_weight;
		logic [FRAC_W-1:0]    uniform_fraction;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [ENERGY_W-1:0]  chosen_energy;
		logic [INDEX_W-1:0]   chosen_index;
	} rsp_t;

	function automatic int idx_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int cnt_bits(input int n);
		return $clog2(n + 1);
	endfunction

	function automatic int cum_bits(input int n, input int w);
		return w + $clog2(n);
	endfunction

	function automatic int entry_bits(input int n, input int w);
		return KIND_W + idx_bits(n) + ENERGY_W + cum_bits(n, w);
	endfunction

endpackage

>>> rtl/core/wls_queue.sv
module wls_queue import wls_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = idx_bits(DEPTH),
	localparam int CNT_W = cnt_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/wls_front.sv
module wls_front import wls_pkg::*; #(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int IDX_W   = idx_bits(MAX_LINES),
	localparam int CNT_W   = cnt_bits(MAX_LINES),
	localparam int CW      = cum_bits(MAX_LINES, WEIGHT_BITS),
	localparam int ENTRY_W = entry_bits(MAX_LINES, WEIGHT_BITS),
	localparam int WEFF    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_t               cmd,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output logic [ENTRY_W-1:0] push_data
);

	typedef struct packed {
		op_kind_t            kind;
		logic [IDX_W-1:0]    idx;
		logic [ENERGY_W-1:0] data;
		logic [CW-1:0]       cum;
	} entry_t;

	logic [CNT_W-1:0] count_q;
	logic [CW-1:0]    total_q;
	logic [CW-1:0]    weight_eff;
	logic [CW-1:0]    sum;
	logic             table_full;
	logic             accept;
	logic             do_add;
	entry_t           entry;

	assign busy       = q_full;
	assign accept     = start && !q_full;
	assign push       = accept;
	assign weight_eff = CW'(cmd.line_weight[WEFF-1:0]);
	assign sum        = total_q + weight_eff;
	assign table_full = (count_q == CNT_W'(MAX_LINES));
	assign do_add     = accept && (cmd.command == CMD_ADD) && !table_full;
	assign push_data  = ENTRY_W'(entry);

	always_comb begin
		entry      = '0;
		entry.kind = OP_EMPTY;
		if (cmd.command == CMD_ADD) begin
			if (table_full) begin
				entry.kind = OP_FULL;
			end else begin
				entry.kind = OP_ADD;
				entry.idx  = IDX_W'(count_q);
				entry.data = cmd.line_energy;
				entry.cum  = sum;
			end
		end else if (count_q != '0) begin
			entry.kind = OP_SAMPLE;
			entry.idx  = IDX_W'(count_q - CNT_W'(1));
			entry.data = cmd.uniform_fraction;
			entry.cum  = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (do_add) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= sum;
		end
	end

endmodule

>>> rtl/core/wls_back.sv
module wls_back import wls_pkg::*; #(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int IDX_W   = idx_bits(MAX_LINES),
	localparam int CW      = cum_bits(MAX_LINES, WEIGHT_BITS),
	localparam int ENTRY_W = entry_bits(MAX_LINES, WEIGHT_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  logic [ENTRY_W-1:0] q_head,
	output logic               pop,
	output logic               done,
	output rsp_t               rsp
);

	typedef struct packed {
		op_kind_t            kind;
		logic [IDX_W-1:0]    idx;
		logic [ENERGY_W-1:0] data;
		logic [CW-1:0]       cum;
	} entry_t;

	logic [ENERGY_W-1:0] energy_mem [MAX_LINES];
	logic [CW-1:0]       cum_mem    [MAX_LINES];

	back_state_t         state_q;
	back_state_t         state_d;
	entry_t              head_e;
	entry_t              ent_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CW-1:0]       thr_q;
	logic [63:0]         lo_q;
	logic [63:0]         hi_q;
	logic [63:0]         tot64;
	logic [31:0]         mul_b;
	logic [63:0]         mul_p;
	logic [ENERGY_W-1:0] rd_energy_q;
	logic [CW-1:0]       rd_cum_q;
	logic                found;
	logic                wr_en;
	logic                rd_en;
	logic                emit;
	rsp_t                emit_rsp;
	logic                done_q;
	rsp_t                rsp_q;

	assign head_e = entry_t'(q_head);
	assign tot64  = 64'(ent_q.cum);
	assign mul_b  = (state_q == BK_MUL_LO) ? tot64[31:0] : tot64[63:32];
	assign mul_p  = 64'(ent_q.data) * 64'(mul_b);
	assign found  = (rd_cum_q >= thr_q) || (idx_q == ent_q.idx);
	assign done   = done_q;
	assign rsp    = rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && head_e.kind == OP_SAMPLE) begin
					state_d = BK_MUL_LO;
				end
			end
			BK_MUL_LO: state_d = BK_MUL_HI;
			BK_MUL_HI: state_d = BK_THR;
			BK_THR:    state_d = BK_READ;
			BK_READ:   state_d = BK_CMP;
			BK_CMP: begin
				state_d = found ? BK_IDLE : BK_READ;
			end
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		unique case (state_q)
			BK_IDLE: begin
				pop = q_valid;
				if (q_valid) begin
					unique case (head_e.kind)
						OP_ADD: begin
							wr_en                 = 1'b1;
							emit                  = 1'b1;
							emit_rsp.status       = STAT_ADDED;
							emit_rsp.chosen_index = INDEX_W'(head_e.idx);
						end
						OP_FULL: begin
							emit            = 1'b1;
							emit_rsp.status = STAT_FULL;
						end
						OP_EMPTY: begin
							emit            = 1'b1;
							emit_rsp.status = STAT_EMPTY;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			BK_READ: rd_en = 1'b1;
			BK_CMP: begin
				if (found) begin
					emit                   = 1'b1;
					emit_rsp.status        = STAT_SAMPLED;
					emit_rsp.chosen_energy = rd_energy_q;
					emit_rsp.chosen_index  = INDEX_W'(idx_q);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			energy_mem[head_e.idx] <= head_e.data;
			cum_mem[head_e.idx]    <= head_e.cum;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_energy_q <= energy_mem[idx_q];
			rd_cum_q    <= cum_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head_e;
		end
		if (state_q == BK_MUL_LO) begin
			lo_q <= mul_p;
		end
		if (state_q == BK_MUL_HI) begin
			hi_q <= mul_p;
		end
		if (state_q == BK_THR) begin
			thr_q <= CW'(hi_q + (lo_q >> 32) + 64'(lo_q[31:0] != '0));
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == BK_THR) begin
				idx_q <= '0;
			end else if (state_q == BK_CMP && !found) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// The search never walks past the last line held when the sample was queued.
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CMP) |-> (idx_q <= ent_q.idx))
		else $error("search index beyond last line");

	// The threshold can never exceed the total weight.
	a_thr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ || state_q == BK_CMP) |-> (thr_q <= ent_q.cum))
		else $error("threshold above total weight");

	// A result beat follows either a direct command or the end of a search.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == BK_CMP || ($past(state_q) == BK_IDLE && $past(q_valid))))
		else $error("result beat without a source");

	// A sample leaves the queue only from idle and starts the multiply.
	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL_LO) |-> ($past(state_q) == BK_IDLE && ent_q.kind == OP_SAMPLE))
		else $error("multiply started without a sample");
`endif

endmodule

>>> rtl/core/weighted_line_sampler.sv
// An add, or a command refused as full or empty, gives its registered result beat once
// popped; a sample picking line p multiplies, sets a threshold, then reads lines 0 to p.
// Throughput: the two-entry queue takes a command per cycle while it has room; the
// sample engine shares one 32x32 multiplier and reads one table entry per compare step.
// Reset clears the line count and control state; the line table is left as is.
// Result beats cannot be stalled by the receiver.
module weighted_line_sampler import wls_pkg::*; #(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int ENTRY_W = entry_bits(MAX_LINES, WEIGHT_BITS);

	logic               q_full;
	logic               q_push;
	logic [ENTRY_W-1:0] q_push_data;
	logic               q_pop;
	logic               q_valid;
	logic [ENTRY_W-1:0] q_head;

	wls_front #(
		.MAX_LINES   (MAX_LINES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.q_full    (q_full),
		.busy      (busy),
		.push      (q_push),
		.push_data (q_push_data)
	);

	wls_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	wls_back #(
		.MAX_LINES   (MAX_LINES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

>>> dv/weighted_line_sampler_test.sv
`timescale 1ns / 1ps

module weighted_line_sampler_test;
	import wls_pkg::*;

	localparam int SUM_W = WEIGHT_BITS_DEF + $clog2(MAX_LINES_DEF);
	localparam int RANDOM_BEATS = 700;
	localparam int STALL_LIMIT = 2000;

	class line_table_scoreboard;
		int lines;
		logic [ENERGY_W-1:0] energies[MAX_LINES_DEF];
		logic [SUM_W-1:0] sums[MAX_LINES_DEF];
		rsp_t awaited[$];
		int faults;

		function new();
			lines = 0;
			faults = 0;
		endfunction

		function void note_command(cmd_t c);
			rsp_t want;
			logic [SUM_W-1:0] total;
			logic [SUM_W-1:0] prior;
			logic [63:0] product;
			logic [63:0] threshold;
			int pick;
			want.status = STAT_SAMPLED;
			want.chosen_energy = '0;
			want.chosen_index = '0;
			if (c.command == CMD_ADD) begin
				if (lines >= MAX_LINES_DEF) begin
					want.status = STAT_FULL;
				end else begin
					prior = (lines == 0) ? '0 : sums[lines-1];
					energies[lines] = c.line_energy;
					sums[lines] = prior + SUM_W'(c.line_weight[WEIGHT_BITS_DEF-1:0]);
					want.status = STAT_ADDED;
					want.chosen_index = INDEX_W'(lines);
					lines++;
				end
			end else if (lines == 0) begin
				want.status = STAT_EMPTY;
			end else begin
				// The first line whose running sum reaches ceil(u * total / 2^32) wins.
				total = sums[lines-1];
				product = 64'(c.uniform_fraction) * 64'(total);
				threshold = (product >> 32) + 64'(product[31:0] != 32'd0);
				pick = lines - 1;
				for (int i = 0; i < lines; i++) begin
					if (64'(sums[i]) >= threshold) begin
						pick = i;
						break;
					end
				end
				want.chosen_energy = energies[pick];
				want.chosen_index = INDEX_W'(pick);
			end
			awaited = {awaited, want};
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("result beat with nothing expected: status %0d energy %0h index %0d",
					got.status, got.chosen_energy, got.chosen_index);
				faults++;
				return;
			end
			want = awaited.pop_front();
			if (got.status != want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				faults++;
			end
			if (got.chosen_energy != want.chosen_energy) begin
				$error("chosen_energy: expected %0h, got %0h", want.chosen_energy,
					got.chosen_energy);
				faults++;
			end
			if (got.chosen_index != want.chosen_index) begin
				$error("chosen_index: expected %0d, got %0d", want.chosen_index,
					got.chosen_index);
				faults++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;

	line_table_scoreboard sb = new();
	int stall_cycles;
	int calm_left;

	weighted_line_sampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_command(cmd);
		end
		if (arst_n && done) begin
			sb.check_response(rsp);
		end
		if ((arst_n && start && !busy) || (arst_n && done)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 59) == 0) begin
			calm_left = $urandom_range(10, 40);
		end
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			return $urandom_range(8, 40);
		end
		if (roll < 8) begin
			return $urandom_range(1, 3);
		end
		return 0;
	endfunction

	task automatic send_beat(input cmd_t c);
		int gap;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input command_t op, input logic [ENERGY_W-1:0] energy,
			input logic [WEIGHT_W-1:0] weight, input logic [FRAC_W-1:0] frac);
		cmd_t c;
		c.command = op;
		c.line_energy = energy;
		c.line_weight = weight;
		c.uniform_fraction = frac;
		send_beat(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	function automatic logic [FRAC_W-1:0] draw_fraction();
		int roll;
		int line;
		logic [SUM_W-1:0] total;
		logic [63:0] edge_point;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end
		if (roll == 1) begin
			return '1;
		end
		if (roll < 5 && sb.lines > 0) begin
			// Aim at a boundary between two lines, where rounding matters most.
			total = sb.sums[sb.lines-1];
			if (total != '0) begin
				line = $urandom_range(0, sb.lines - 1);
				edge_point = (64'(sb.sums[line]) << 32) / 64'(total);
				return edge_point[31:0] + FRAC_W'($urandom_range(0, 2)) - FRAC_W'(1);
			end
		end
		return $urandom();
	endfunction

	function automatic logic [WEIGHT_W-1:0] draw_weight();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return WEIGHT_W'($urandom_range(1, 15));
			end
			default: begin
				return WEIGHT_W'($urandom());
			end
		endcase
	endfunction

	function automatic logic [ENERGY_W-1:0] draw_energy();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	initial begin
		command_t op;
		start <= 1'b0;
		cmd <= '0;
		arst_n <= 1'b0;
		stall_cycles <= 0;
		calm_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), $urandom());
		issue(CMD_ADD, '0, '0, '1);
		issue(CMD_SAMPLE, '1, '1, '0);
		issue(CMD_SAMPLE, '0, '0, '1);
		issue(CMD_ADD, '1, '1, '0);
		issue(CMD_ADD, 32'h1234_5678, '0, $urandom());
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), '1);
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), '0);
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), 32'h0000_0001);
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), 32'h8000_0000);
		issue(CMD_ADD, 32'hA5A5_A5A5, 16'h0001, $urandom());
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), 32'hFFFF_FFFE);
		issue(CMD_SAMPLE, $urandom(), WEIGHT_W'($urandom()), 32'h7FFF_FFFF);

		drain();
		@(posedge clk);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			op = ($urandom_range(0, 99) < 12) ? CMD_ADD : CMD_SAMPLE;
			if (op == CMD_ADD) begin
				issue(op, draw_energy(), draw_weight(), $urandom());
			end else begin
				issue(op, $urandom(), WEIGHT_W'($urandom()), draw_fraction());
			end
			if ($urandom_range(0, 49) == 0) begin
				drain();
				@(posedge clk);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.faults == 0 && sb.awaited.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/wls_pkg.sv
rtl/core/wls_queue.sv
rtl/core/wls_front.sv
rtl/core/wls_back.sv
rtl/core/weighted_line_sampler.sv
dv/weighted_line_sampler_test.sv
